// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker in tra_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/tra_pkg.sv =====
package tra_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] TILE_DIM_RESET = 7'd64;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } tra_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit;
  } tra_cmd_t;

endpackage

// ===== rtl/tra_if.sv =====
interface tra_in_if import tra_pkg::*;;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink (input valid, input cmd, input pixel_in, output ready);
endinterface

interface tra_out_if import tra_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_out;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               last;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output last, input ready);
  modport sink (input valid, input pixel_out, input out_row, input out_col,
                input last, output ready);
endinterface

// ===== rtl/tra_ctrl.sv =====
module tra_ctrl import tra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tra_cmd_t cmd
);

  tra_state_t state_r, state_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_EMPTY: begin
        in_ready = 1'b1;
      end
      ST_FULL: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          state_nxt = ST_EMPTY;
        end
      end
      default: begin
        state_nxt = ST_EMPTY;
      end
    endcase
    accept   = in_valid && in_ready;
    cmd.load = accept && (in_cmd == CMD_LOAD);
    cmd.emit = accept && (in_cmd == CMD_EMIT);
    // A new emit refills the output slot in the same cycle it drains.
    if (cmd.emit) begin
      state_nxt = ST_FULL;
    end
  end

endmodule

// ===== rtl/tra_datapath.sv =====
module tra_datapath import tra_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tra_cmd_t              cmd,
  input  logic [PIX_W-1:0]      in_pixel,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [PIX_W-1:0]      pixel_out,
  output logic [COORD_W-1:0]    out_row,
  output logic [COORD_W-1:0]    out_col,
  output logic                  out_last
);

  localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = CW + 1;
  localparam int EW    = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
  localparam int DEPTH = 1 << (2 * CW);

  logic [CFG_DATA_W-1:0] rows_cfg_r, cols_cfg_r;
  rot_t                  rot_r;
  logic [CW-1:0]         lr_r, lc_r, er_r, ec_r;
  logic [CW-1:0]         lr_nxt, lc_nxt, er_nxt, ec_nxt;
  logic [CW-1:0]         lr_cur, lc_cur, r, c, si, sj;
  logic [DW-1:0]         rows, cols, trows, tcols;
  logic                  is_last;
  logic [PIX_W-1:0]      mem [0:DEPTH-1];
  logic [PIX_W-1:0]      rd_data_r;
  logic [COORD_W-1:0]    row_r, col_r;
  logic                  last_r;
  logic [CW+COORD_W-1:0] row_ext, col_ext;
  logic                  cfg_hit;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [EW-1:0] ve;
    ve = EW'(v);
    if (ve == '0) begin
      return DW'(1);
    end else if (ve > EW'(MAX_DIM)) begin
      return DW'(MAX_DIM);
    end
    return DW'(ve);
  endfunction

  assign rows  = clamp_dim(rows_cfg_r);
  assign cols  = clamp_dim(cols_cfg_r);
  assign trows = rot_r[0] ? cols : rows;
  assign tcols = rot_r[0] ? rows : cols;

  // Load position: raster order over the source tile.
  always_comb begin
    lr_cur = lr_r;
    lc_cur = lc_r;
    if (DW'(lr_r) >= rows || DW'(lc_r) >= cols) begin
      lr_cur = '0;
      lc_cur = '0;
    end
    if (DW'(lc_cur) + DW'(1) >= cols) begin
      lc_nxt = '0;
      lr_nxt = (DW'(lr_cur) + DW'(1) >= rows) ? '0 : lr_cur + CW'(1);
    end else begin
      lc_nxt = lc_cur + CW'(1);
      lr_nxt = lr_cur;
    end
  end

  // Emit position: raster order over the target tile, mapped back to source.
  always_comb begin
    r = er_r;
    c = ec_r;
    if (DW'(er_r) >= trows || DW'(ec_r) >= tcols) begin
      r = '0;
      c = '0;
    end
    unique case (rot_r)
      ROT_90: begin
        si = CW'(rows - DW'(1) - DW'(c));
        sj = r;
      end
      ROT_180: begin
        si = CW'(rows - DW'(1) - DW'(r));
        sj = CW'(cols - DW'(1) - DW'(c));
      end
      ROT_270: begin
        si = c;
        sj = CW'(cols - DW'(1) - DW'(r));
      end
      default: begin
        si = r;
        sj = c;
      end
    endcase
    is_last = (DW'(r) + DW'(1) == trows) && (DW'(c) + DW'(1) == tcols);
    if (DW'(c) + DW'(1) >= tcols) begin
      ec_nxt = '0;
      er_nxt = (DW'(r) + DW'(1) >= trows) ? '0 : r + CW'(1);
    end else begin
      ec_nxt = c + CW'(1);
      er_nxt = r;
    end
  end

  assign cfg_hit = cfg_we && (cfg_index == CFG_TILE_ROWS || cfg_index == CFG_TILE_COLS ||
                              cfg_index == CFG_ROTATION);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= TILE_DIM_RESET;
      cols_cfg_r <= TILE_DIM_RESET;
      rot_r      <= ROT_0;
      lr_r       <= '0;
      lc_r       <= '0;
      er_r       <= '0;
      ec_r       <= '0;
    end else if (cfg_hit) begin
      // Any register write restarts both positions; the stored tile stays.
      unique case (cfg_index)
        CFG_TILE_ROWS: rows_cfg_r <= cfg_wdata;
        CFG_TILE_COLS: cols_cfg_r <= cfg_wdata;
        default:       rot_r      <= rot_t'(cfg_wdata[1:0]);
      endcase
      lr_r <= '0;
      lc_r <= '0;
      er_r <= '0;
      ec_r <= '0;
    end else begin
      if (cmd.load) begin
        lr_r <= lr_nxt;
        lc_r <= lc_nxt;
      end
      if (cmd.emit) begin
        er_r <= er_nxt;
        ec_r <= ec_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[{lr_cur, lc_cur}] <= in_pixel;
    end
    if (cmd.emit) begin
      rd_data_r <= mem[{si, sj}];
    end
  end

  assign row_ext = {{COORD_W{1'b0}}, r};
  assign col_ext = {{COORD_W{1'b0}}, c};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_r  <= row_ext[COORD_W-1:0];
      col_r  <= col_ext[COORD_W-1:0];
      last_r <= is_last;
    end
  end

  assign pixel_out = rd_data_r;
  assign out_row   = row_r;
  assign out_col   = col_r;
  assign out_last  = last_r;

endmodule

// ===== rtl/tile_rotate_right_angles.sv =====
// Channel   Dir  Payload                           Beat when
// in_ch     in   cmd, pixel_in                     valid && ready
// out_ch    out  pixel_out, out_row, out_col, last valid && ready
// cfg_*     in   cfg_index, cfg_wdata              cfg_we
//
// One beat per cycle in either direction while the output is not stalled; an
// emit shows its pixel in the cycle after acceptance, from the registered read port of the tile memory.
// A load makes no output beat and writes the memory in its accept cycle.
// While an output beat stalls, the input is held off; ready returns in the
// cycle the output is taken. Synchronous reset needs no clearing pass.
module tile_rotate_right_angles import tra_pkg::*; #(
  parameter int MAX_DIM = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tra_in_if.sink                in_ch,
  tra_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tra_cmd_t cmd;

  tra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  tra_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_pixel  (in_ch.pixel_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pixel_out (out_ch.pixel_out),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_last  (out_ch.last)
  );

endmodule

// ===== rtl/tra_checker.sv =====
`include "assert_macros.svh"

module tra_checker import tra_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_cmd,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_pixel
);

  logic in_beat, out_stall;

  assign in_beat   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)
  `ASSERT_NEXT(a_pixel_hold, clk, rst_n, out_stall, $stable(out_pixel))
  `ASSERT_NEXT(a_emit_gives_beat, clk, rst_n, in_beat && (in_cmd == CMD_EMIT), out_valid)
  `ASSERT_NEXT(a_load_no_beat, clk, rst_n,
               in_beat && (in_cmd == CMD_LOAD) && (!out_valid || out_ready), !out_valid)
  `ASSERT_SAME(a_stall_blocks_in, clk, rst_n, out_stall, !in_ready)

endmodule

bind tile_rotate_right_angles tra_checker u_tra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pixel (out_ch.pixel_out)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tra_pkg::*;

  localparam int MAX_DIM = 64;
  localparam int CYCLE_LIMIT = 2_000_000;
  // Index past the last register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } rot_pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tra_in_if  in_ch ();
  tra_out_if out_ch ();

  tile_rotate_right_angles #(.MAX_DIM(MAX_DIM)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow of the rotator state.
  logic [PIX_W-1:0]      tile_mem [MAX_DIM*MAX_DIM];
  bit                    written [MAX_DIM*MAX_DIM];
  logic [CFG_DATA_W-1:0] rows_reg;
  logic [CFG_DATA_W-1:0] cols_reg;
  rot_t                  rot_reg;
  int                    load_r, load_c, emit_r, emit_c;

  rot_pixel_t pixels_due[$];
  int         mismatch_count = 0;
  int         beats_sent = 0;
  int         cycle_count = 0;
  bit         idle_on;

  function automatic int clamp_dim(logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void rotator_write_reg(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TILE_ROWS: rows_reg = data;
      CFG_TILE_COLS: cols_reg = data;
      CFG_ROTATION:  rot_reg = rot_t'(data[1:0]);
      default:       return;
    endcase
    load_r = 0;
    load_c = 0;
    emit_r = 0;
    emit_c = 0;
  endfunction

  function automatic void rotator_accept(logic c, logic [PIX_W-1:0] p);
    int rows, cols, trows, tcols, si, sj;
    rot_pixel_t res;
    rows = clamp_dim(rows_reg);
    cols = clamp_dim(cols_reg);
    if (c == CMD_LOAD) begin
      if (load_r >= rows || load_c >= cols) begin
        load_r = 0;
        load_c = 0;
      end
      tile_mem[load_r*MAX_DIM + load_c] = p;
      written[load_r*MAX_DIM + load_c] = 1'b1;
      if (load_c + 1 >= cols) begin
        load_c = 0;
        load_r = (load_r + 1 >= rows) ? 0 : load_r + 1;
      end else begin
        load_c++;
      end
    end else begin
      trows = rot_reg[0] ? cols : rows;
      tcols = rot_reg[0] ? rows : cols;
      if (emit_r >= trows || emit_c >= tcols) begin
        emit_r = 0;
        emit_c = 0;
      end
      case (rot_reg)
        ROT_90: begin
          si = rows - 1 - emit_c;
          sj = emit_r;
        end
        ROT_180: begin
          si = rows - 1 - emit_r;
          sj = cols - 1 - emit_c;
        end
        ROT_270: begin
          si = emit_c;
          sj = cols - 1 - emit_r;
        end
        default: begin
          si = emit_r;
          sj = emit_c;
        end
      endcase
      res.pixel = tile_mem[si*MAX_DIM + sj];
      res.row   = COORD_W'(emit_r);
      res.col   = COORD_W'(emit_c);
      res.last  = (emit_r + 1 == trows) && (emit_c + 1 == tcols);
      pixels_due.push_back(res);
      if (emit_c + 1 >= tcols) begin
        emit_c = 0;
        emit_r = (emit_r + 1 >= trows) ? 0 : emit_r + 1;
      end else begin
        emit_c++;
      end
    end
  endfunction

  // Store address that the next emit reads, after the end-of-tile wrap.
  function automatic int emit_source();
    int rows, cols, trows, tcols, r, c, si, sj;
    rows  = clamp_dim(rows_reg);
    cols  = clamp_dim(cols_reg);
    trows = rot_reg[0] ? cols : rows;
    tcols = rot_reg[0] ? rows : cols;
    r = emit_r;
    c = emit_c;
    if (r >= trows || c >= tcols) begin
      r = 0;
      c = 0;
    end
    case (rot_reg)
      ROT_90: begin
        si = rows - 1 - c;
        sj = r;
      end
      ROT_180: begin
        si = rows - 1 - r;
        sj = cols - 1 - c;
      end
      ROT_270: begin
        si = c;
        sj = cols - 1 - r;
      end
      default: begin
        si = r;
        sj = c;
      end
    endcase
    return si*MAX_DIM + sj;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_item(input logic c, input logic [PIX_W-1:0] p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.pixel_in <= p;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    rotator_accept(c, p);
    beats_sent++;
  endtask

  // An emit whose source entry has never been loaded goes out as a load.
  task automatic send_guarded(input logic c);
    if (c == CMD_EMIT && !written[emit_source()]) c = CMD_LOAD;
    send_item(c, PIX_W'($urandom));
  endtask

  task automatic load_pixels(input int n);
    repeat (n) send_item(CMD_LOAD, PIX_W'($urandom));
  endtask

  task automatic emit_pixels(input int n);
    repeat (n) send_item(CMD_EMIT, PIX_W'($urandom));
  endtask

  // Registers change only with the block drained; a load leaves no beat
  // behind, so the task idles after the drain for its memory write to settle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    rotator_write_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  // Reset sizes give the full 64 by 64 tile; its first row is loaded and
  // read back, which covers the full column coordinate width.
  task automatic test_reset_tile();
    load_pixels(MAX_DIM);
    emit_pixels(MAX_DIM);
  endtask

  task automatic test_rotations();
    rot_t r;
    write_reg(CFG_TILE_ROWS, 7'd2);
    write_reg(CFG_TILE_COLS, 7'd3);
    send_item(CMD_LOAD, 8'h00);
    send_item(CMD_LOAD, 8'hFF);
    send_item(CMD_LOAD, 8'h55);
    send_item(CMD_LOAD, 8'hAA);
    send_item(CMD_LOAD, 8'h01);
    send_item(CMD_LOAD, 8'h80);
    r = ROT_0;
    repeat (4) begin
      write_reg(CFG_ROTATION, {5'd0, r});
      emit_pixels(6);
      r = r.next();
    end
  endtask

  // Zero sizes act as one and oversized ones as the maximum.
  task automatic test_size_limits();
    write_reg(CFG_TILE_ROWS, 7'd0);
    write_reg(CFG_TILE_COLS, 7'd127);
    write_reg(CFG_ROTATION, {5'd0, ROT_90});
    load_pixels(4);
    emit_pixels(3);
    write_reg(CFG_TILE_ROWS, 7'd65);
    write_reg(CFG_TILE_COLS, 7'd0);
    write_reg(CFG_ROTATION, {5'd0, ROT_270});
    load_pixels(3);
    emit_pixels(2);
    write_reg(CFG_SPARE, 7'h7F);
    emit_pixels(1);
  endtask

  task automatic test_wrap_and_restart();
    write_reg(CFG_TILE_ROWS, 7'd1);
    write_reg(CFG_TILE_COLS, 7'd2);
    write_reg(CFG_ROTATION, {5'd0, ROT_180});
    load_pixels(3);
    emit_pixels(3);
    load_pixels(1);
    write_reg(CFG_TILE_COLS, 7'd2);
    load_pixels(2);
    emit_pixels(2);
  endtask

  task automatic test_random_tiles(input int n_items);
    int first, kind, n;
    logic [CFG_DATA_W-1:0] d_rows, d_cols;
    first = beats_sent;
    while (beats_sent - first < n_items) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        d_rows = CFG_DATA_W'($urandom_range(0, 8));
        d_cols = CFG_DATA_W'($urandom_range(0, 8));
        // Now and then one long side, kept narrow so the tile stays cheap.
        if ($urandom_range(0, 15) == 0) begin
          if ($urandom_range(0, 1)) begin
            d_rows = CFG_DATA_W'($urandom_range(9, 127));
            d_cols = CFG_DATA_W'($urandom_range(1, 4));
          end else begin
            d_rows = CFG_DATA_W'($urandom_range(1, 4));
            d_cols = CFG_DATA_W'($urandom_range(9, 127));
          end
        end
        write_reg(CFG_TILE_ROWS, d_rows);
        write_reg(CFG_TILE_COLS, d_cols);
      end
      // Upper data bits are junk; only the low two select the angle.
      write_reg(CFG_ROTATION, CFG_DATA_W'($urandom_range(0, 127)));
      n = clamp_dim(rows_reg) * clamp_dim(cols_reg);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        load_pixels(n);
        emit_pixels(n + $urandom_range(0, 2));
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 20))
          send_guarded(logic'($urandom_range(0, 1)));
      end else begin
        load_pixels($urandom_range(1, n));
        repeat ($urandom_range(1, n)) send_guarded(CMD_EMIT);
      end
    end
  endtask

  task automatic test_back_to_back();
    write_reg(CFG_TILE_ROWS, 7'd5);
    write_reg(CFG_TILE_COLS, 7'd7);
    write_reg(CFG_ROTATION, {5'd0, ROT_90});
    load_pixels(35);
    emit_pixels(36);
    repeat (10) begin
      send_item(CMD_LOAD, PIX_W'($urandom));
      send_item(CMD_EMIT, PIX_W'($urandom));
    end
  endtask

  initial begin : ready_gen
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rot_pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixels_due.size() == 0) begin
        $error("unexpected output beat: pixel_out %0d row %0d col %0d",
               out_ch.pixel_out, out_ch.out_row, out_ch.out_col);
        mismatch_count++;
      end else begin
        want = pixels_due.pop_front();
        if (out_ch.pixel_out !== want.pixel) begin
          $error("pixel_out expected %0d, got %0d", want.pixel, out_ch.pixel_out);
          mismatch_count++;
        end
        if (out_ch.out_row !== want.row) begin
          $error("out_row expected %0d, got %0d", want.row, out_ch.out_row);
          mismatch_count++;
        end
        if (out_ch.out_col !== want.col) begin
          $error("out_col expected %0d, got %0d", want.col, out_ch.out_col);
          mismatch_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last expected %0d, got %0d", want.last, out_ch.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_TILE_ROWS;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_LOAD;
    in_ch.pixel_in <= '0;
    rows_reg = TILE_DIM_RESET;
    cols_reg = TILE_DIM_RESET;
    rot_reg  = ROT_0;
    load_r   = 0;
    load_c   = 0;
    emit_r   = 0;
    emit_c   = 0;
    idle_on  = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_tile();
    test_rotations();
    test_size_limits();
    test_wrap_and_restart();
    test_random_tiles(200);
    idle_on = 1'b0;
    test_back_to_back();

    in_ch.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
